@@ design/thc_pkg.sv @@
// shared types, constants and bit-count functions for the trng health test
`default_nettype none
package thc_pkg;

	localparam int WINDOW_WORDS = 32;
	localparam int WORD_W = 32;
	localparam int CNT_W = 6;
	localparam int RUN_W = 10;
	localparam int RCT_W = 10;
	localparam int APT_W = 11;
	localparam int WARM_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int POS_W = $clog2(WINDOW_WORDS);
	localparam int WIN_SUM_W = $clog2(WINDOW_WORDS * WORD_W + 1);
	localparam int CMP_W = (WIN_SUM_W > APT_W) ? WIN_SUM_W : APT_W;

	localparam logic [CFG_IDX_W-1:0] REG_RCT_CUTOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APT_CUTOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_WORDS = 2'd2;

	localparam logic [RCT_W-1:0] RCT_CUTOFF_RST = 10'd64;
	localparam logic [APT_W-1:0] APT_CUTOFF_RST = 11'd624;
	localparam logic [WARM_W-1:0] WARMUP_WORDS_RST = 8'd64;

	// per-word features taken from one sample word
	typedef struct packed {
		logic [CNT_W-1:0] lz;
		logic [CNT_W-1:0] tz;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] to;
		logic [CNT_W-1:0] pc;
		logic             all_zero;
		logic             all_one;
		logic             restart;
	} thc_feat_t;

	// window state after the word now being retired into it
	typedef struct packed {
		logic [WIN_SUM_W-1:0] sum;
		logic                 full;
	} thc_win_t;

	function automatic logic [CNT_W-1:0] ones_in(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] v;
		v = w - ((w >> 1) & 32'h5555_5555);
		v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
		v = (v + (v >> 4)) & 32'h0F0F_0F0F;
		v = v + (v >> 8);
		v = v + (v >> 16);
		return v[CNT_W-1:0];
	endfunction

	// bit i set when bits 31..i are all zero
	function automatic logic [CNT_W-1:0] lead_zeros(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = ~|(w & ({WORD_W{1'b1}} << i));
		end
		return ones_in(m);
	endfunction

	// bit i set when bits i..0 are all zero
	function automatic logic [CNT_W-1:0] trail_zeros(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = ~|(w & ({WORD_W{1'b1}} >> (WORD_W - 1 - i)));
		end
		return ones_in(m);
	endfunction

endpackage
`default_nettype wire

@@ design/thc_if.sv @@
// valid/ready channel interfaces for sample words and test results
`default_nettype none
interface thc_in_if;
	logic                        valid;
	logic                        ready;
	logic [thc_pkg::WORD_W-1:0]  sample_word;
	logic                        restart;

	modport source(output valid, output sample_word, output restart, input ready);
	modport sink(input valid, input sample_word, input restart, output ready);
endinterface

interface thc_out_if;
	logic valid;
	logic ready;
	logic rct_fail;
	logic apt_fail;
	logic startup_passed;

	modport source(output valid, output rct_fail, output apt_fail, output startup_passed,
		input ready);
	modport sink(input valid, input rct_fail, input apt_fail, input startup_passed,
		output ready);
endinterface
`default_nettype wire

@@ design/thc_scan.sv @@
// first stage: run lengths and ones count of the incoming word, registered
`default_nettype none
module thc_scan (
	input  wire logic                       clk,
	input  wire logic                       load,
	input  wire logic [thc_pkg::WORD_W-1:0] word,
	input  wire logic                       restart,
	output thc_pkg::thc_feat_t              feat_s1
);

	logic [thc_pkg::WORD_W-1:0] nw;

	assign nw = ~word;

	always_ff @(posedge clk) begin
		if (load) begin
			feat_s1.lz <= thc_pkg::lead_zeros(word);
			feat_s1.tz <= thc_pkg::trail_zeros(word);
			feat_s1.lo <= thc_pkg::lead_zeros(nw);
			feat_s1.to <= thc_pkg::trail_zeros(nw);
			feat_s1.pc <= thc_pkg::ones_in(word);
			feat_s1.all_zero <= ~|word;
			feat_s1.all_one <= &word;
			feat_s1.restart <= restart;
		end
	end

endmodule
`default_nettype wire

@@ design/thc_cell.sv @@
// one window slot: holds a word's ones count and passes it to the next slot
`default_nettype none
module thc_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      shift,
	input  wire logic [thc_pkg::CNT_W-1:0] d,
	output logic      [thc_pkg::CNT_W-1:0] q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= d;
		end
	end

endmodule
`default_nettype wire

@@ design/thc_window.sv @@
// sliding window of per-word ones counts as a chain of cells, with running sum
`default_nettype none
module thc_window (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      shift,
	input  wire logic                      restart,
	input  wire logic [thc_pkg::CNT_W-1:0] pc,
	output thc_pkg::thc_win_t              nxt
);

	localparam logic [thc_pkg::POS_W-1:0] LAST_POS = thc_pkg::POS_W'(thc_pkg::WINDOW_WORDS - 1);

	logic [thc_pkg::CNT_W-1:0]     slot [thc_pkg::WINDOW_WORDS];
	logic [thc_pkg::WIN_SUM_W-1:0] sum_q;
	logic [thc_pkg::POS_W-1:0]     pos_q;
	logic                          full_q;

	for (genvar i = 0; i < thc_pkg::WINDOW_WORDS; i++) begin : g_cell
		if (i == 0) begin : g_head
			thc_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(pc), .q(slot[i]));
		end else begin : g_body
			thc_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(slot[i-1]),
				.q(slot[i]));
		end
	end

	// last cell holds the word that leaves the window now
	always_comb begin
		nxt.sum = sum_q - thc_pkg::WIN_SUM_W'(slot[thc_pkg::WINDOW_WORDS-1])
			+ thc_pkg::WIN_SUM_W'(pc);
		nxt.full = (full_q && !restart) || (pos_q == LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
			full_q <= 1'b0;
		end else if (shift) begin
			sum_q <= nxt.sum;
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
			full_q <= nxt.full;
		end
	end

endmodule
`default_nettype wire

@@ design/trng_continuous_health_test_core.sv @@
// Continuous health tests (repetition count and adaptive proportion) on packed
// TRNG sample words. One word is taken per clock cycle when the result side
// keeps up; a result passes through the feature register (run lengths and ones
// count) and then the result register, where the carried runs, warm-up count and
// window sum are updated.
// The window is a chain of WINDOW_WORDS cells that shift once per word. There
// is no clearing pass after reset; the block accepts words right away.
`default_nettype none
module trng_continuous_health_test_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [thc_pkg::CFG_DATA_W-1:0] cfg_data,
	thc_in_if.sink                              samples,
	thc_out_if.source                           results
);

	localparam logic [thc_pkg::CMP_W-1:0] WIN_BITS =
		thc_pkg::CMP_W'(thc_pkg::WINDOW_WORDS * thc_pkg::WORD_W);

	logic [thc_pkg::RCT_W-1:0]  rct_cutoff_q;
	logic [thc_pkg::APT_W-1:0]  apt_cutoff_q;
	logic [thc_pkg::WARM_W-1:0] warmup_words_q;

	logic [thc_pkg::RUN_W-1:0]  zero_run_q;
	logic [thc_pkg::RUN_W-1:0]  one_run_q;
	logic [thc_pkg::WARM_W-1:0] warmup_count_q;

	logic               s1_valid_q;
	logic               out_valid_q;
	logic               rct_fail_q;
	logic               apt_fail_q;
	logic               passed_q;
	logic               out_free;
	logic               adv;
	logic               load;
	thc_pkg::thc_feat_t feat_s1;
	thc_pkg::thc_win_t  win;

	logic [thc_pkg::RUN_W:0]    zero_sum;
	logic [thc_pkg::RUN_W:0]    one_sum;
	logic                       rfail;
	logic [thc_pkg::RUN_W-1:0]  zero_run_nxt;
	logic [thc_pkg::RUN_W-1:0]  one_run_nxt;
	logic [thc_pkg::WARM_W-1:0] warm_base;
	logic [thc_pkg::WARM_W-1:0] warm_nxt;
	logic [thc_pkg::CMP_W-1:0]  sum_c;
	logic [thc_pkg::CMP_W-1:0]  apt_c;
	logic                       afail;
	logic                       passed;

	// handshake and pipeline advance
	assign out_free = !out_valid_q || results.ready;
	assign adv = s1_valid_q && out_free;
	assign samples.ready = !s1_valid_q || out_free;
	assign load = samples.valid && samples.ready;

	assign results.valid = out_valid_q;
	assign results.rct_fail = rct_fail_q;
	assign results.apt_fail = apt_fail_q;
	assign results.startup_passed = passed_q;

	thc_scan u_scan (
		.clk(clk),
		.load(load),
		.word(samples.sample_word),
		.restart(samples.restart),
		.feat_s1(feat_s1)
	);

	thc_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.shift(adv),
		.restart(feat_s1.restart),
		.pc(feat_s1.pc),
		.nxt(win)
	);

	// repetition count test, joining trailing run to the carried leading run
	always_comb begin
		zero_sum = {1'b0, zero_run_q} + (thc_pkg::RUN_W + 1)'(feat_s1.tz);
		one_sum = {1'b0, one_run_q} + (thc_pkg::RUN_W + 1)'(feat_s1.to);
		rfail = (zero_sum >= {1'b0, rct_cutoff_q}) || (one_sum >= {1'b0, rct_cutoff_q});
		zero_run_nxt = feat_s1.all_zero ? zero_run_q + thc_pkg::RUN_W'(feat_s1.lz)
			: thc_pkg::RUN_W'(feat_s1.lz);
		one_run_nxt = feat_s1.all_one ? one_run_q + thc_pkg::RUN_W'(feat_s1.lo)
			: thc_pkg::RUN_W'(feat_s1.lo);
		warm_base = feat_s1.restart ? '0 : warmup_count_q;
		if (!rfail && (warm_base < warmup_words_q)) begin
			warm_nxt = warm_base + 1'b1;
		end else begin
			warm_nxt = warm_base;
		end
	end

	// adaptive proportion test on the updated window sum
	always_comb begin
		sum_c = thc_pkg::CMP_W'(win.sum);
		apt_c = thc_pkg::CMP_W'(apt_cutoff_q);
		afail = win.full && ((sum_c > apt_c)
			|| ((apt_c <= WIN_BITS) && (sum_c < WIN_BITS - apt_c)));
		passed = (warm_nxt >= warmup_words_q) && win.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rct_cutoff_q <= thc_pkg::RCT_CUTOFF_RST;
			apt_cutoff_q <= thc_pkg::APT_CUTOFF_RST;
			warmup_words_q <= thc_pkg::WARMUP_WORDS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thc_pkg::REG_RCT_CUTOFF: rct_cutoff_q <= cfg_data[thc_pkg::RCT_W-1:0];
				thc_pkg::REG_APT_CUTOFF: apt_cutoff_q <= cfg_data[thc_pkg::APT_W-1:0];
				thc_pkg::REG_WARMUP_WORDS: warmup_words_q <= cfg_data[thc_pkg::WARM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			zero_run_q <= '0;
			one_run_q <= '0;
			warmup_count_q <= '0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				warmup_count_q <= warm_nxt;
				if (!rfail) begin
					zero_run_q <= zero_run_nxt;
					one_run_q <= one_run_nxt;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rct_fail_q <= rfail;
			apt_fail_q <= afail;
			passed_q <= passed;
		end
	end

	// a failed repetition test leaves the carried runs untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rfail) |=> ($stable(zero_run_q) && $stable(one_run_q)))
		else $error("carried run changed on a repetition failure");

	// warm-up count only steps up by one, or restarts from zero or one
	assert property (@(posedge clk) disable iff (!arst_n)
		(warmup_count_q != $past(warmup_count_q)) |->
		((warmup_count_q == $past(warmup_count_q) + 8'd1) || (warmup_count_q <= 8'd1)))
		else $error("warm-up count moved by more than one");

	// a word held in the feature stage stays until it moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |=> s1_valid_q)
		else $error("feature stage lost a word");

endmodule
`default_nettype wire
